### hdl/peum_pkg.sv
// Shared types, register codes and helpers for the elastic pull velocity update.
// Used by every module of the block; depends on nothing.
`default_nettype none
package peum_pkg;

  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 31;
  localparam logic [33:0] MAG_CAP    = 34'h1_FFFF_FFFF;

  localparam logic [30:0] RST_DAMP_SPEED     = 31'd2097152;
  localparam logic [31:0] RST_PULL_GAIN      = 32'd125829;
  localparam logic [31:0] RST_START_AGE      = 32'd26214;
  localparam logic [15:0] RST_DAMPING_FACTOR = 16'd31130;
  localparam logic [30:0] RST_JITTER_RADIUS  = 31'd3145728;

  typedef enum logic [2:0] {
    REG_DAMP_SPEED     = 3'd0,
    REG_PULL_GAIN      = 3'd1,
    REG_START_AGE      = 3'd2,
    REG_DAMPING_FACTOR = 3'd3,
    REG_JITTER_RADIUS  = 3'd4,
    REG_ANCHOR_X       = 3'd5,
    REG_ANCHOR_Y       = 3'd6,
    REG_ANCHOR_Z       = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [30:0]      damp_speed;
    logic [31:0]      pull_gain;
    logic [31:0]      start_age;
    logic [15:0]      damping_factor;
    logic [30:0]      jitter_radius;
    logic [2:0][31:0] anchor;
  } cfg_t;

  // Per-item data that rides alongside the square root and divide pipes.
  typedef struct packed {
    logic [2:0][31:0] tgt;
    logic [2:0][33:0] vd;
    logic [33:0]      mag;
    logic             affected;
    logic             damped;
    logic             nopull;
  } side_t;

  function automatic logic [31:0] sat32(input logic [35:0] x);
    logic [31:0] r;
    if (!x[35] && (x[34:31] != 4'h0)) begin
      r = 32'h7FFF_FFFF;
    end else if (x[35] && (x[34:31] != 4'hF)) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/peum_if.sv
// Valid/ready channel interfaces for particle words in and velocity words out.
// Depends on nothing but the port widths of the block.
`default_nettype none
interface peum_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] particle_age;
  logic [31:0] step_time;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic signed [15:0] jitter_x;
  logic signed [15:0] jitter_y;
  logic signed [15:0] jitter_z;

  modport source (output valid, particle_age, step_time, pos_x, pos_y, pos_z,
                  vel_x, vel_y, vel_z, jitter_x, jitter_y, jitter_z, input ready);
  modport sink (input valid, particle_age, step_time, pos_x, pos_y, pos_z,
                vel_x, vel_y, vel_z, jitter_x, jitter_y, jitter_z, output ready);
endinterface

interface peum_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] new_vel_x;
  logic signed [31:0] new_vel_y;
  logic signed [31:0] new_vel_z;
  logic        was_affected;
  logic        was_damped;

  modport source (output valid, new_vel_x, new_vel_y, new_vel_z, was_affected,
                  was_damped, input ready);
  modport sink (input valid, new_vel_x, new_vel_y, new_vel_z, was_affected,
                was_damped, output ready);
endinterface
`default_nettype wire

### hdl/peum_front.sv
// Front pipe: target vector, squared lengths, damping decision and pull magnitude.
// Nine register stages; uses peum_pkg.
`default_nettype none
module peum_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  peum_pkg::cfg_t      cfg_i,
  input  logic [31:0]         age_i,
  input  logic [31:0]         step_i,
  input  logic [2:0][31:0]    pos_i,
  input  logic [2:0][31:0]    vel_i,
  input  logic [2:0][15:0]    jit_i,
  output logic                valid_o,
  output logic [63:0]         d2_o,
  output peum_pkg::side_t     side_o
);
  import peum_pkg::*;

  logic [8:0] vld_q;

  logic             aff0_q, aff1_q, aff2_q, aff3_q, aff4_q, aff5_q, aff6_q, aff7_q;
  logic [31:0]      step0_q, step1_q, step2_q, step3_q, step4_q, step5_q, step6_q;
  logic [2:0][31:0] pos0_q, pos1_q;
  logic [2:0][31:0] vel0_q, vel1_q, vel2_q, vel3_q, vel4_q, vel5_q;
  logic [2:0][15:0] jit0_q;
  logic [2:0][32:0] off1_q;
  logic [2:0][31:0] t2_q, t3_q, t4_q, t5_q, t6_q, t7_q;
  logic [2:0][63:0] tt3_q, vv3_q, vt3_q;
  logic [63:0]      d2_4_q, d2_5_q, d2_6_q, d2_7_q, d2_8_q;
  logic [63:0]      v2_4_q;
  logic [61:0]      lim4_q;
  logic             np4_q;
  logic             dmp5_q, dmp6_q, dmp7_q;
  logic [2:0][47:0] vdp5_q;
  logic [63:0]      pfl5_q, pfh5_q;
  logic [2:0][33:0] vd6_q, vd7_q;
  logic [55:0]      spd6_q;
  logic [63:0]      psl7_q;
  logic [55:0]      psh7_q;
  side_t            side8_q;

  logic signed [47:0] joff   [3];
  logic signed [47:0] joff_s [3];
  logic signed [34:0] tsum   [3];
  logic [2:0][31:0]   t_d;
  logic [2:0][63:0]   tt_d, vv_d, vt_d;
  logic [63:0]        d2_d, v2_d;
  logic signed [65:0] dot_d;
  logic               dmp_d;
  logic [2:0][47:0]   vdp_d;
  logic signed [47:0] vds    [3];
  logic [2:0][33:0]   vd_d;
  logic [95:0]        fsum;
  logic [87:0]        psum;
  logic [71:0]        mraw;
  logic [33:0]        mag_d;

  always_comb begin
    dot_d = '0;
    d2_d  = '0;
    v2_d  = '0;
    for (int i = 0; i < 3; i++) begin
      joff[i]   = 48'($signed(jit0_q[i])) * 48'($signed({1'b0, cfg_i.jitter_radius}));
      joff_s[i] = joff[i] >>> 15;
      tsum[i]   = $signed({{3{cfg_i.anchor[i][31]}}, cfg_i.anchor[i]})
                - $signed({{3{pos1_q[i][31]}}, pos1_q[i]})
                + $signed({{2{off1_q[i][32]}}, off1_q[i]});
      t_d[i]    = sat32({tsum[i][34], tsum[i]});
      tt_d[i]   = 64'($signed(t2_q[i])) * 64'($signed(t2_q[i]));
      vv_d[i]   = 64'($signed(vel2_q[i])) * 64'($signed(vel2_q[i]));
      vt_d[i]   = 64'($signed(vel2_q[i])) * 64'($signed(t2_q[i]));
      d2_d      = d2_d + tt3_q[i];
      v2_d      = v2_d + vv3_q[i];
      dot_d     = dot_d + $signed({{2{vt3_q[i][63]}}, vt3_q[i]});
      vdp_d[i]  = 48'($signed(vel4_q[i])) * 48'($signed({1'b0, cfg_i.damping_factor}));
      vds[i]    = $signed(vdp5_q[i]) >>> 15;
      vd_d[i]   = dmp5_q ? vds[i][33:0] : {{2{vel5_q[i][31]}}, vel5_q[i]};
    end
    dmp_d = aff4_q && (v2_4_q > {2'b00, lim4_q}) && np4_q;
    fsum  = {pfh5_q, 32'h0} + {32'h0, pfl5_q};
    psum  = {psh7_q, 32'h0} + {24'h0, psl7_q};
    mraw  = psum[87:16];
    mag_d = (mraw[71:33] != '0) ? MAG_CAP : mraw[33:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[7:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      aff0_q  <= age_i >= cfg_i.start_age;
      step0_q <= step_i;
      pos0_q  <= pos_i;
      vel0_q  <= vel_i;
      jit0_q  <= jit_i;

      aff1_q  <= aff0_q;
      step1_q <= step0_q;
      pos1_q  <= pos0_q;
      vel1_q  <= vel0_q;
      for (int i = 0; i < 3; i++) begin
        off1_q[i] <= joff_s[i][32:0];
      end

      aff2_q  <= aff1_q;
      step2_q <= step1_q;
      vel2_q  <= vel1_q;
      t2_q    <= t_d;

      aff3_q  <= aff2_q;
      step3_q <= step2_q;
      vel3_q  <= vel2_q;
      t3_q    <= t2_q;
      tt3_q   <= tt_d;
      vv3_q   <= vv_d;
      vt3_q   <= vt_d;

      aff4_q  <= aff3_q;
      step4_q <= step3_q;
      vel4_q  <= vel3_q;
      t4_q    <= t3_q;
      d2_4_q  <= d2_d;
      v2_4_q  <= v2_d;
      lim4_q  <= {31'd0, cfg_i.damp_speed} * {31'd0, cfg_i.damp_speed};
      np4_q   <= dot_d[65] || (dot_d == '0);

      aff5_q  <= aff4_q;
      step5_q <= step4_q;
      vel5_q  <= vel4_q;
      t5_q    <= t4_q;
      d2_5_q  <= d2_4_q;
      dmp5_q  <= dmp_d;
      vdp5_q  <= vdp_d;
      pfl5_q  <= {32'd0, cfg_i.pull_gain} * {32'd0, d2_4_q[31:0]};
      pfh5_q  <= {32'd0, cfg_i.pull_gain} * {32'd0, d2_4_q[63:32]};

      aff6_q  <= aff5_q;
      step6_q <= step5_q;
      t6_q    <= t5_q;
      d2_6_q  <= d2_5_q;
      dmp6_q  <= dmp5_q;
      vd6_q   <= vd_d;
      spd6_q  <= fsum[95:40];

      aff7_q  <= aff6_q;
      t7_q    <= t6_q;
      d2_7_q  <= d2_6_q;
      dmp7_q  <= dmp6_q;
      vd7_q   <= vd6_q;
      psl7_q  <= {32'd0, spd6_q[31:0]} * {32'd0, step6_q};
      psh7_q  <= {32'd0, spd6_q[55:32]} * {24'd0, step6_q};

      d2_8_q           <= d2_7_q;
      side8_q.tgt      <= t7_q;
      side8_q.vd       <= vd7_q;
      side8_q.mag      <= mag_d;
      side8_q.affected <= aff7_q;
      side8_q.damped   <= dmp7_q;
      side8_q.nopull   <= !aff7_q || (d2_7_q == '0);
    end
  end

  assign valid_o = vld_q[8];
  assign d2_o    = d2_8_q;
  assign side_o  = side8_q;

endmodule
`default_nettype wire

### hdl/peum_sqrt.sv
// Integer square root of the squared target length, one result bit per stage.
// Thirty-two register stages; uses peum_pkg.
`default_nettype none
module peum_sqrt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [63:0]     d2_i,
  input  peum_pkg::side_t side_i,
  output logic            valid_o,
  output logic [31:0]     len_o,
  output peum_pkg::side_t side_o
);
  import peum_pkg::*;

  logic        vld_q  [SQRT_STEPS];
  logic [63:0] rad_q  [SQRT_STEPS];
  logic [32:0] rem_q  [SQRT_STEPS];
  logic [31:0] root_q [SQRT_STEPS];
  side_t       side_q [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_stage
    logic        vld_p;
    logic [63:0] rad_p;
    logic [32:0] rem_p;
    logic [31:0] root_p;
    side_t       side_p;
    logic [34:0] sh, trial, diff;
    logic        ge;

    if (k == 0) begin : g_first
      assign vld_p  = valid_i;
      assign rad_p  = d2_i;
      assign rem_p  = '0;
      assign root_p = '0;
      assign side_p = side_i;
    end else begin : g_next
      assign vld_p  = vld_q[k-1];
      assign rad_p  = rad_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign side_p = side_q[k-1];
    end

    // bring down the next two radicand bits and try the next root bit
    assign sh    = {rem_p, rad_p[63:62]};
    assign trial = {1'b0, root_p, 2'b01};
    assign diff  = sh - trial;
    assign ge    = sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= {rad_p[61:0], 2'b00};
        rem_q[k]  <= ge ? diff[32:0] : sh[32:0];
        root_q[k] <= {root_p[30:0], ge};
        side_q[k] <= side_p;
      end
    end
  end

  assign valid_o = vld_q[SQRT_STEPS-1];
  assign len_o   = root_q[SQRT_STEPS-1];
  assign side_o  = side_q[SQRT_STEPS-1];

endmodule
`default_nettype wire

### hdl/peum_div.sv
// Three-lane restoring divider: |target| * 2^30 / length, one quotient bit per stage.
// Thirty-one register stages; uses peum_pkg.
`default_nettype none
module peum_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [31:0]      len_i,
  input  peum_pkg::side_t  side_i,
  output logic             valid_o,
  output logic [2:0][30:0] quo_o,
  output peum_pkg::side_t  side_o
);
  import peum_pkg::*;

  logic             vld_q  [DIV_STEPS];
  logic [31:0]      len_q  [DIV_STEPS];
  logic [2:0][31:0] rem_q  [DIV_STEPS];
  logic [2:0][30:0] quo_q  [DIV_STEPS];
  side_t            side_q [DIV_STEPS];

  logic [2:0][31:0] mag_t;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_t[i] = side_i.tgt[i][31] ? (32'd0 - side_i.tgt[i]) : side_i.tgt[i];
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
    logic             vld_p;
    logic [31:0]      len_p;
    logic [2:0][31:0] rem_p;
    logic [2:0][30:0] quo_p;
    side_t            side_p;
    logic [2:0]       nbit;
    logic [2:0][32:0] sh, diff;
    logic [2:0]       ge;

    if (k == 0) begin : g_first
      // the dividend is |t| followed by thirty zero bits
      assign vld_p  = valid_i;
      assign len_p  = len_i;
      assign quo_p  = '0;
      assign side_p = side_i;
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_p[i] = {1'b0, mag_t[i][31:1]};
        assign nbit[i]  = mag_t[i][0];
      end
    end else begin : g_next
      assign vld_p  = vld_q[k-1];
      assign len_p  = len_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign quo_p  = quo_q[k-1];
      assign side_p = side_q[k-1];
      assign nbit   = '0;
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        sh[i]   = {rem_p[i], nbit[i]};
        diff[i] = sh[i] - {1'b0, len_p};
        ge[i]   = sh[i] >= {1'b0, len_p};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        len_q[k]  <= len_p;
        side_q[k] <= side_p;
        for (int i = 0; i < 3; i++) begin
          rem_q[k][i] <= ge[i] ? diff[i][31:0] : sh[i][31:0];
          quo_q[k][i] <= {quo_p[i][29:0], ge[i]};
        end
      end
    end
  end

  assign valid_o = vld_q[DIV_STEPS-1];
  assign quo_o   = quo_q[DIV_STEPS-1];
  assign side_o  = side_q[DIV_STEPS-1];

endmodule
`default_nettype wire

### hdl/peum_out.sv
// Pull components, final add with saturation and the output register.
// Two register stages; uses peum_pkg.
`default_nettype none
module peum_out (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [2:0][30:0] quo_i,
  input  peum_pkg::side_t  side_i,
  output logic             valid_o,
  output logic [2:0][31:0] vel_o,
  output logic             affected_o,
  output logic             damped_o
);
  import peum_pkg::*;

  logic             vldp_q;
  logic [2:0][66:0] prod_q;
  logic [2:0][33:0] vdp_q;
  logic             affp_q, dmpp_q, nopp_q;

  logic             vld_q;
  logic [2:0][31:0] vel_q;
  logic             aff_q, dmp_q;

  logic [2:0][31:0]   unit_d;
  logic [2:0][66:0]   prod_d;
  logic signed [66:0] pull_s [3];
  logic [2:0][35:0]   res_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // sign of the target restores the truncated quotient's sign
      unit_d[i] = side_i.tgt[i][31] ? (32'd0 - {1'b0, quo_i[i]}) : {1'b0, quo_i[i]};
      prod_d[i] = 67'($signed(unit_d[i])) * 67'($signed({1'b0, side_i.mag}));
      pull_s[i] = nopp_q ? 67'sd0 : ($signed(prod_q[i]) >>> 30);
      res_d[i]  = $signed({{2{vdp_q[i][33]}}, vdp_q[i]}) + $signed(pull_s[i][35:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vldp_q <= 1'b0;
      vld_q  <= 1'b0;
    end else if (en_i) begin
      vldp_q <= valid_i;
      vld_q  <= vldp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      vdp_q  <= side_i.vd;
      affp_q <= side_i.affected;
      dmpp_q <= side_i.damped;
      nopp_q <= side_i.nopull;
      for (int i = 0; i < 3; i++) begin
        vel_q[i] <= sat32(res_d[i]);
      end
      aff_q  <= affp_q;
      dmp_q  <= dmpp_q;
    end
  end

  assign valid_o    = vld_q;
  assign vel_o      = vel_q;
  assign affected_o = aff_q;
  assign damped_o   = dmp_q;

endmodule
`default_nettype wire

### hdl/particle_elastic_pull_update.sv
// Elastic pull velocity update: top level with configuration registers and pipe.
// Depends on peum_pkg, peum_if, peum_front, peum_sqrt, peum_div and peum_out.
//
// Usage: particle words enter on in_if (valid/ready) and updated velocity words
// leave on out_if in the same order, one out for each one in. Configuration is
// written through cfg_we_i / cfg_idx_i / cfg_data_i while the pipe is empty.
// An accepted word passes 9 front stages, 32 square-root stages, 31 divider
// stages and 2 output stages before its result appears on out_if. Every stage
// is a fixed register slice, and the square root and the three divides each
// resolve one bit per stage. Throughput: one word per cycle unless stalled.
// Reset clears all valid bits and loads the register defaults; the pipe comes
// out of reset empty and ready.
// When the receiver holds ready low with a word waiting, the whole pipe freezes
// in place and in_if.ready drops; nothing is lost or repeated, and a word can
// be accepted in the same cycle the waiting result is taken.
`default_nettype none
module particle_elastic_pull_update (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  peum_in_if.sink           in_if,
  peum_out_if.source        out_if
);
  import peum_pkg::*;

  cfg_t cfg_q;

  logic             en;
  logic             fr_valid, sq_valid, dv_valid, out_valid;
  logic [63:0]      fr_d2;
  side_t            fr_side, sq_side, dv_side;
  logic [31:0]      sq_len;
  logic [2:0][30:0] dv_quo;
  logic [2:0][31:0] out_vel;
  logic             out_aff, out_dmp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.damp_speed     <= RST_DAMP_SPEED;
      cfg_q.pull_gain      <= RST_PULL_GAIN;
      cfg_q.start_age      <= RST_START_AGE;
      cfg_q.damping_factor <= RST_DAMPING_FACTOR;
      cfg_q.jitter_radius  <= RST_JITTER_RADIUS;
      cfg_q.anchor         <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_DAMP_SPEED:     cfg_q.damp_speed     <= cfg_data_i[30:0];
        REG_PULL_GAIN:      cfg_q.pull_gain      <= cfg_data_i;
        REG_START_AGE:      cfg_q.start_age      <= cfg_data_i;
        REG_DAMPING_FACTOR: cfg_q.damping_factor <= cfg_data_i[15:0];
        REG_JITTER_RADIUS:  cfg_q.jitter_radius  <= cfg_data_i[30:0];
        REG_ANCHOR_X:       cfg_q.anchor[0]      <= cfg_data_i;
        REG_ANCHOR_Y:       cfg_q.anchor[1]      <= cfg_data_i;
        REG_ANCHOR_Z:       cfg_q.anchor[2]      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // advance the whole pipe unless a finished word is stuck at the output
  assign en          = !out_valid || out_if.ready;
  assign in_if.ready = en;

  peum_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_if.valid),
    .cfg_i   (cfg_q),
    .age_i   (in_if.particle_age),
    .step_i  (in_if.step_time),
    .pos_i   ({in_if.pos_z, in_if.pos_y, in_if.pos_x}),
    .vel_i   ({in_if.vel_z, in_if.vel_y, in_if.vel_x}),
    .jit_i   ({in_if.jitter_z, in_if.jitter_y, in_if.jitter_x}),
    .valid_o (fr_valid),
    .d2_o    (fr_d2),
    .side_o  (fr_side)
  );

  peum_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .d2_i    (fr_d2),
    .side_i  (fr_side),
    .valid_o (sq_valid),
    .len_o   (sq_len),
    .side_o  (sq_side)
  );

  peum_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .len_i   (sq_len),
    .side_i  (sq_side),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  peum_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (dv_valid),
    .quo_i      (dv_quo),
    .side_i     (dv_side),
    .valid_o    (out_valid),
    .vel_o      (out_vel),
    .affected_o (out_aff),
    .damped_o   (out_dmp)
  );

  assign out_if.valid        = out_valid;
  assign out_if.new_vel_x    = out_vel[0];
  assign out_if.new_vel_y    = out_vel[1];
  assign out_if.new_vel_z    = out_vel[2];
  assign out_if.was_affected = out_aff;
  assign out_if.was_damped   = out_dmp;

endmodule
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for particle_elastic_pull_update: predicts each velocity
// word in fixed point and compares it field by field. Depends on peum_pkg and peum_if.
`timescale 1ns / 1ps
module testbench;
  import peum_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned PIPE_DRAIN  = 120;

  typedef struct {
    logic [31:0] age;
    logic [31:0] step;
    logic signed [31:0] pos [3];
    logic signed [31:0] vel [3];
    logic signed [15:0] jit [3];
  } particle_t;

  typedef struct {
    logic signed [31:0] vel [3];
    logic affected;
    logic damped;
  } vel_word_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [31:0] cfg_data_i;

  peum_in_if  in_bus ();
  peum_out_if out_bus ();

  particle_elastic_pull_update u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_bus),
    .out_if     (out_bus)
  );

  // Shadow of the configuration registers.
  logic [30:0] sh_rev_limit;
  logic [31:0] sh_dist_factor;
  logic [31:0] sh_start_age;
  logic [15:0] sh_damping;
  logic [30:0] sh_radius;
  logic signed [31:0] sh_anchor [3];

  particle_t particle_q [$];
  vel_word_t vel_expect_q [$];
  particle_t cur_item;
  int unsigned mismatches;
  int unsigned cycles;
  bit idle_on;
  int hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic logic [63:0] root64(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic vel_word_t predict_vel(particle_t p);
    vel_word_t r;
    longint tv [3];
    longint vv [3];
    longint off;
    longint mag;
    longint u;
    longint pull;
    logic [63:0] d2;
    logic [63:0] v2;
    logic [63:0] lim2;
    logic [63:0] root_len;
    logic signed [66:0] dot;
    logic [127:0] sp;
    logic [127:0] mg;
    d2 = 0;
    v2 = 0;
    dot = 0;
    mag = 0;
    for (int i = 0; i < 3; i++) vv[i] = p.vel[i];
    r.affected = (p.age >= sh_start_age);
    r.damped = 1'b0;
    if (r.affected) begin
      for (int i = 0; i < 3; i++) begin
        off = (longint'(p.jit[i]) * longint'(sh_radius)) >>> 15;
        tv[i] = clamp32(longint'(sh_anchor[i]) - longint'(p.pos[i]) + off);
        d2 = d2 + 64'(tv[i] * tv[i]);
        v2 = v2 + 64'(vv[i] * vv[i]);
        dot = dot + 67'(vv[i] * tv[i]);
      end
      lim2 = 64'(sh_rev_limit) * 64'(sh_rev_limit);
      if (v2 > lim2 && dot <= 0) begin
        r.damped = 1'b1;
        for (int i = 0; i < 3; i++) vv[i] = (vv[i] * longint'(sh_damping)) >>> 15;
      end
      root_len = 0;
      if (d2 != 0) begin
        sp = (128'(sh_dist_factor) * 128'(d2)) >> 40;
        mg = (sp * 128'(p.step)) >> 16;
        mag = (mg > 128'(MAG_CAP)) ? longint'(MAG_CAP) : longint'(mg[63:0]);
        root_len = root64(d2);
      end
      for (int i = 0; i < 3; i++) begin
        pull = 0;
        if (root_len != 0) begin
          u = (tv[i] * (64'sd1 <<< 30)) / longint'(root_len);
          pull = (u * mag) >>> 30;
        end
        vv[i] = vv[i] + pull;
      end
    end
    for (int i = 0; i < 3; i++) r.vel[i] = 32'(clamp32(vv[i]));
    return r;
  endfunction

  // Driver: offer the next particle word at the falling edge.
  bit in_fire;
  int gap_in;
  always @(posedge clk_i) in_fire <= in_bus.valid && in_bus.ready;

  always @(negedge clk_i) begin
    if (rst_ni && (!in_bus.valid || in_fire)) begin
      if (gap_in > 0) begin
        in_bus.valid <= 1'b0;
        gap_in <= gap_in - 1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        in_bus.valid <= 1'b0;
        gap_in <= $urandom_range(0, 13);
      end else if (particle_q.size() > 0) begin
        cur_item <= particle_q[0];
        in_bus.particle_age <= particle_q[0].age;
        in_bus.step_time <= particle_q[0].step;
        in_bus.pos_x <= particle_q[0].pos[0];
        in_bus.pos_y <= particle_q[0].pos[1];
        in_bus.pos_z <= particle_q[0].pos[2];
        in_bus.vel_x <= particle_q[0].vel[0];
        in_bus.vel_y <= particle_q[0].vel[1];
        in_bus.vel_z <= particle_q[0].vel[2];
        in_bus.jitter_x <= particle_q[0].jit[0];
        in_bus.jitter_y <= particle_q[0].jit[1];
        in_bus.jitter_z <= particle_q[0].jit[2];
        in_bus.valid <= 1'b1;
        particle_q.pop_front();
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off.
  int gap_out;
  int hold_left;
  int hold_seen;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= 400;
        out_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_bus.ready <= 1'b0;
      end else if (gap_out > 0) begin
        gap_out <= gap_out - 1;
        out_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        gap_out <= $urandom_range(0, 13);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Monitor: record accepted particles, check accepted velocity words.
  always @(posedge clk_i) begin
    vel_word_t want;
    if (in_bus.valid && in_bus.ready) vel_expect_q.push_back(predict_vel(cur_item));
    if (out_bus.valid && out_bus.ready) begin
      if (vel_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected velocity word at cycle %0d", cycles);
      end else begin
        want = vel_expect_q.pop_front();
        if (out_bus.new_vel_x !== want.vel[0] || out_bus.new_vel_y !== want.vel[1] ||
            out_bus.new_vel_z !== want.vel[2] || out_bus.was_affected !== want.affected ||
            out_bus.was_damped !== want.damped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("cycle %0d: exp %h %h %h a%b d%b got %h %h %h a%b d%b", cycles,
                     want.vel[0], want.vel[1], want.vel[2], want.affected, want.damped,
                     out_bus.new_vel_x, out_bus.new_vel_y, out_bus.new_vel_z,
                     out_bus.was_affected, out_bus.was_damped);
        end
      end
    end
  end

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
      2: return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
      3: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  function automatic particle_t rand_particle();
    particle_t p;
    p.age = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 26214) : pick32();
    if ($urandom_range(0, 9) > 1) p.age = sh_start_age + $urandom_range(0, 32'h0001_0000);
    p.step = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0000_2000);
    for (int i = 0; i < 3; i++) begin
      p.pos[i] = pick32();
      p.vel[i] = pick32();
      p.jit[i] = 16'($urandom);
    end
    // Aim some particles toward the origin, at a sixteenth of their position.
    if ($urandom_range(0, 3) == 0)
      for (int i = 0; i < 3; i++) p.vel[i] = -(p.pos[i] >>> 4);
    return p;
  endfunction

  function automatic particle_t make_particle(logic [31:0] age, logic [31:0] step,
      logic [31:0] pos, logic [31:0] vel, logic [15:0] jit);
    particle_t p;
    p.age = age;
    p.step = step;
    for (int i = 0; i < 3; i++) begin
      p.pos[i] = pos;
      p.vel[i] = vel;
      p.jit[i] = jit;
    end
    return p;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    case (idx)
      REG_DAMP_SPEED:      sh_rev_limit = value[30:0];
      REG_PULL_GAIN:       sh_dist_factor = value;
      REG_START_AGE:       sh_start_age = value;
      REG_DAMPING_FACTOR:  sh_damping = value[15:0];
      REG_JITTER_RADIUS:   sh_radius = value[30:0];
      REG_ANCHOR_X:        sh_anchor[0] = value;
      REG_ANCHOR_Y:        sh_anchor[1] = value;
      default:             sh_anchor[2] = value;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    wait (particle_q.size() == 0 && !in_bus.valid && vel_expect_q.size() == 0);
    repeat (PIPE_DRAIN) @(negedge clk_i);
  endtask

  task automatic load_directed();
    particle_t p;
    particle_q.push_back(make_particle(32'd0, 32'h0001_0000, 32'h0010_0000, 32'h0001_0000, 16'h0));
    particle_q.push_back(make_particle(sh_start_age, 32'h0001_0000, 32'h0010_0000, 32'h0, 16'h0));
    particle_q.push_back(make_particle(sh_start_age - 1, 32'hFFFF_FFFF, 32'h8000_0000,
                                       32'h7FFF_FFFF, 16'h7FFF));
    particle_q.push_back(make_particle(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                       32'h8000_0000, 16'h8000));
    particle_q.push_back(make_particle(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
                                       32'h7FFF_FFFF, 16'h7FFF));
    // Zero-length target: position on the anchor, no jitter.
    p = make_particle(32'hFFFF_FFFF, 32'h0001_0000, 32'h0, 32'h0100_0000, 16'h0);
    for (int i = 0; i < 3; i++) p.pos[i] = sh_anchor[i];
    particle_q.push_back(p);
    p.vel[0] = 32'h0000_1000;
    particle_q.push_back(p);
    // Fast and heading outward.
    p = make_particle(32'h0010_0000, 32'h0000_4000, 32'h03E8_0000, 32'h0040_0000, 16'h0);
    particle_q.push_back(p);
    p.vel[1] = 32'hFFC0_0000;
    particle_q.push_back(p);
    particle_q.push_back(make_particle(32'h0010_0000, 32'h0000_4000, 32'h03E8_0000,
                                       32'hFFC0_0000, 16'h4000));
    particle_q.push_back(make_particle(32'h0010_0000, 32'h0000_0000, 32'hFFFF_0000,
                                       32'h0000_0001, 16'hFFFF));
    particle_q.push_back(make_particle(32'h0010_0000, 32'h0000_0001, 32'h0000_0001,
                                       32'hFFFF_FFFF, 16'h0001));
    particle_q.push_back(make_particle(32'h0, 32'h0, 32'h0, 32'h0, 16'h0));
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_DAMP_SPEED;
    cfg_data_i = 32'd0;
    in_bus.valid = 1'b0;
    in_bus.particle_age = 32'd0;
    in_bus.step_time = 32'd0;
    in_bus.pos_x = 32'd0;
    in_bus.pos_y = 32'd0;
    in_bus.pos_z = 32'd0;
    in_bus.vel_x = 32'd0;
    in_bus.vel_y = 32'd0;
    in_bus.vel_z = 32'd0;
    in_bus.jitter_x = 16'd0;
    in_bus.jitter_y = 16'd0;
    in_bus.jitter_z = 16'd0;
    out_bus.ready = 1'b0;
    mismatches = 0;
    cycles = 0;
    idle_on = 1'b1;
    hold_req = 0;
    gap_in = 0;
    gap_out = 0;
    hold_left = 0;
    hold_seen = 0;
    sh_rev_limit = RST_DAMP_SPEED;
    sh_dist_factor = RST_PULL_GAIN;
    sh_start_age = RST_START_AGE;
    sh_damping = RST_DAMPING_FACTOR;
    sh_radius = RST_JITTER_RADIUS;
    for (int i = 0; i < 3; i++) sh_anchor[i] = 32'd0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Defaults after reset.
    load_directed();
    for (int n = 0; n < 60; n++) particle_q.push_back(rand_particle());
    wait_idle();

    // Largest settings.
    write_reg(REG_DAMP_SPEED, 32'hFFFF_FFFF);
    write_reg(REG_PULL_GAIN, 32'hFFFF_FFFF);
    write_reg(REG_START_AGE, 32'hFFFF_FFFF);
    write_reg(REG_DAMPING_FACTOR, 32'hFFFF_FFFF);
    write_reg(REG_JITTER_RADIUS, 32'hFFFF_FFFF);
    write_reg(REG_ANCHOR_X, 32'h7FFF_FFFF);
    write_reg(REG_ANCHOR_Y, 32'h8000_0000);
    write_reg(REG_ANCHOR_Z, 32'h7FFF_FFFF);
    load_directed();
    for (int n = 0; n < 40; n++) particle_q.push_back(rand_particle());
    wait_idle();

    // Smallest settings.
    write_reg(REG_DAMP_SPEED, 32'd0);
    write_reg(REG_PULL_GAIN, 32'd0);
    write_reg(REG_START_AGE, 32'd0);
    write_reg(REG_DAMPING_FACTOR, 32'd0);
    write_reg(REG_JITTER_RADIUS, 32'd0);
    write_reg(REG_ANCHOR_X, 32'h8000_0000);
    write_reg(REG_ANCHOR_Y, 32'd0);
    write_reg(REG_ANCHOR_Z, 32'h8000_0000);
    load_directed();
    for (int n = 0; n < 40; n++) particle_q.push_back(rand_particle());
    wait_idle();

    // Random settings; the second phase fills the pipe against a long stall,
    // the last runs without idling.
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(REG_DAMP_SPEED, $urandom_range(0, 1) ? pick32() : $urandom_range(0, 32'h0100_0000));
      write_reg(REG_PULL_GAIN, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0010_0000));
      write_reg(REG_START_AGE, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0002_0000));
      write_reg(REG_DAMPING_FACTOR, $urandom);
      write_reg(REG_JITTER_RADIUS, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0400_0000));
      for (int a = 0; a < 3; a++)
        write_reg(reg_idx_e'(REG_ANCHOR_X + a), $urandom_range(0, 2) == 0 ? pick32() : 32'd0);
      if (ph == 1) hold_req = hold_req + 1;
      if (ph == 6) idle_on = 1'b0;
      for (int n = 0; n < 110; n++) particle_q.push_back(rand_particle());
      wait_idle();
    end

    if (mismatches == 0 && vel_expect_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
